// File: sv/integer_to_ascii_formatter_assert.svh
// Assertion macros used by the formatter top level.
`ifndef INTEGER_TO_ASCII_FORMATTER_ASSERT_SVH
`define INTEGER_TO_ASCII_FORMATTER_ASSERT_SVH

// Hold cons in the same cycle as ante.
`define ITA_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Hold cons in the cycle after ante.
`define ITA_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/ita_pkg.sv
`default_nettype none

package ita_pkg;

	localparam int BIN_W = 32;
	localparam int BCD_W = 40;

	localparam logic [1:0] MODE_UDEC = 2'd0;
	localparam logic [1:0] MODE_SDEC = 2'd1;
	localparam logic [1:0] MODE_HEX  = 2'd2;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_UPA   = 8'h41;
	localparam logic [7:0] CH_MINUS = 8'h2D;

	localparam logic [3:0] NDIG_DEC = 4'd10;
	localparam logic [3:0] NDIG_HEX = 4'd8;

	// request from the sequencer to the character emitter
	typedef struct packed {
		logic             valid;
		logic             neg;
		logic [3:0]       ndig;
		logic [BCD_W-1:0] digits;
	} ita_load_t;

	// status of the binary to BCD unit
	typedef struct packed {
		logic             done;
		logic [BCD_W-1:0] bcd;
	} ita_conv_t;

	function automatic logic [7:0] glyph(input logic [3:0] d);
		if (d < 4'd10) begin
			return CH_ZERO + {4'd0, d};
		end else begin
			return CH_UPA + {4'd0, d - 4'd10};
		end
	endfunction

endpackage

`default_nettype wire

// File: sv/ita_dabble.sv
`default_nettype none

// Shift-and-add-3 binary to BCD, one input bit per cycle.
module ita_dabble (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       start,
	input  wire  [31:0]               mag,
	output ita_pkg::ita_conv_t        conv
);
	import ita_pkg::*;

	localparam int CNT_W = $clog2(BIN_W);

	logic [BIN_W-1:0] bin_q;
	logic [BCD_W-1:0] bcd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [BCD_W-1:0] adj;

	// add 3 to every digit of 5 or more before the shift
	always_comb begin
		logic [3:0] nib;
		nib = 4'd0;
		for (int i = 0; i < BCD_W / 4; i++) begin
			nib = bcd_q[i*4 +: 4];
			adj[i*4 +: 4] = (nib >= 4'd5) ? nib + 4'd3 : nib;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(BIN_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= mag;
			bcd_q <= '0;
		end else if (busy_q) begin
			bcd_q <= {adj[BCD_W-2:0], bin_q[BIN_W-1]};
			bin_q <= {bin_q[BIN_W-2:0], 1'b0};
		end
	end

	assign conv = {done_q, bcd_q};

endmodule

`default_nettype wire

// File: sv/ita_emit.sv
`default_nettype none

// Drop leading zero digits, then send sign and digits one per handshake.
module ita_emit (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire ita_pkg::ita_load_t load,
	output logic                   m_tvalid,
	input  wire                    m_tready,
	output logic [7:0]             m_tdata,
	output logic                   m_tlast,
	output logic                   done
);
	import ita_pkg::*;

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_SKIP = 2'd1;
	localparam logic [1:0] PH_SEND = 2'd2;

	logic [1:0]       phase_q;
	logic [BCD_W-1:0] dig_q;
	logic [3:0]       cnt_q;
	logic             sign_q;
	logic [3:0]       top;
	logic             take;
	logic             skip_shift;
	logic             send_shift;

	assign top        = dig_q[BCD_W-1 -: 4];
	assign take       = (phase_q == PH_SEND) && m_tready;
	assign skip_shift = (phase_q == PH_SKIP) && (top == 4'd0) && (cnt_q > 4'd1);
	assign send_shift = take && !sign_q && (cnt_q != 4'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cnt_q   <= '0;
			sign_q  <= 1'b0;
		end else begin
			unique case (phase_q)
				PH_IDLE: begin
					if (load.valid) begin
						phase_q <= PH_SKIP;
						cnt_q   <= load.ndig;
						sign_q  <= load.neg;
					end
				end
				PH_SKIP: begin
					if (skip_shift) begin
						cnt_q <= cnt_q - 4'd1;
					end else begin
						phase_q <= PH_SEND;
					end
				end
				PH_SEND: begin
					if (take) begin
						if (sign_q) begin
							sign_q <= 1'b0;
						end else if (cnt_q == 4'd1) begin
							phase_q <= PH_IDLE;
						end else begin
							cnt_q <= cnt_q - 4'd1;
						end
					end
				end
				default: begin
					phase_q <= PH_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((phase_q == PH_IDLE) && load.valid) begin
			dig_q <= load.digits;
		end else if (skip_shift || send_shift) begin
			dig_q <= {dig_q[BCD_W-5:0], 4'd0};
		end
	end

	assign m_tvalid = (phase_q == PH_SEND);
	assign m_tdata  = sign_q ? CH_MINUS : glyph(top);
	assign m_tlast  = !sign_q && (cnt_q == 4'd1);
	assign done     = take && !sign_q && (cnt_q == 4'd1);

endmodule

`default_nettype wire

// File: sv/integer_to_ascii_formatter.sv
// Integer to ASCII formatter.
// Slave side: one request per word; s_tdata holds value, s_tuser holds mode
// (0 unsigned decimal, 1 signed decimal, 2 or 3 upper-case hex).
// Master side: one ASCII character per transfer on m_tdata, most significant
// digit first, with '-' ahead of a negative signed number; m_tlast marks the
// final character. Leading zeros are dropped, zero prints as a single '0'.
// Decimal words go through a shift-and-add-3 unit that takes one input bit per
// cycle; the digits are then handed to the emitter, which drops the leading
// zeros and then sends the characters. Hex words skip the conversion and go
// straight to the emitter. While the receiver stalls, the block waits.
// s_tready is high only while the block is idle; it rises again in the cycle
// after the final character is accepted.
// When m_tready is low the current character holds on m_tdata and m_tlast and
// the block waits. Reset returns the block to idle and drops any word in flight.
`default_nettype none

`include "integer_to_ascii_formatter_assert.svh"

module integer_to_ascii_formatter (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [31:0] s_tdata,   // [31:0] value
	input  wire  [1:0]  s_tuser,   // [1:0] mode
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [7:0]  m_tdata,   // [7:0] char_code
	output logic        m_tlast
);
	import ita_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CONV = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]       state_q;
	logic             neg_q;
	logic             accept;
	logic             is_hex;
	logic             is_neg;
	logic [BIN_W-1:0] mag;
	ita_conv_t        conv;
	ita_load_t        load;
	logic             emit_done;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	// bit 1 of mode selects hex, so mode 3 prints as hex too
	assign is_hex = s_tuser[1];
	assign is_neg = (s_tuser == MODE_SDEC) && s_tdata[BIN_W-1];
	// negation of the most negative value wraps to 2147483648 unsigned
	assign mag    = is_neg ? (BIN_W'(0) - s_tdata) : s_tdata;

	ita_dabble u_dabble (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept && !is_hex),
		.mag    (mag),
		.conv   (conv)
	);

	// hex digits go straight to the emitter, left aligned in the digit register
	always_comb begin
		load.valid  = (accept && is_hex) || conv.done;
		load.neg    = conv.done ? neg_q : 1'b0;
		load.ndig   = conv.done ? NDIG_DEC : NDIG_HEX;
		load.digits = conv.done ? conv.bcd : {s_tdata, {(BCD_W - BIN_W){1'b0}}};
	end

	ita_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.done     (emit_done)
	);

	// sequencer: idle, convert (decimal only), emit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			neg_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						neg_q   <= is_neg;
						state_q <= is_hex ? ST_EMIT : ST_CONV;
					end
				end
				ST_CONV: begin
					if (conv.done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_done) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`ITA_ASSERT_IMP(a_idle_no_output, s_tready, !m_tvalid, "output active while idle")
	`ITA_ASSERT_NXT(a_busy_after_req, s_tvalid && s_tready, !s_tready, "ready after request")
	`ITA_ASSERT_NXT(a_run_ends, m_tvalid && m_tready && m_tlast, !m_tvalid, "run continues")
	`ITA_ASSERT_IMP(a_minus_not_last, m_tvalid && (m_tdata == CH_MINUS), !m_tlast, "minus last")

endmodule

`default_nettype wire

// File: sim/tb_integer_to_ascii_formatter.sv
module tb_integer_to_ascii_formatter;
	timeunit 1ns;
	timeprecision 1ps;

	import ita_pkg::*;

	// Mode 3 is not a mode of its own: bit 1 alone selects hexadecimal.
	localparam logic [1:0] MODE_HEX_ALT = 2'd3;

	localparam int CLK_HALF     = 5;
	localparam int RESET_CYCLES = 12;
	// A decimal word occupies the block longer than a hex word.
	localparam int DRAIN_CYCLES = 64;
	localparam int RANDOM_ITEMS = 150;

	// One character of the expected text.
	typedef struct packed {
		logic [7:0] code;
		logic       last;
	} char_beat_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata  = '0;    // [31:0] value
	logic [1:0]  s_tuser  = '0;    // [1:0] mode
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;          // [7:0] char_code
	logic        m_tlast;

	// Characters still owed by the block, oldest first.
	char_beat_t pending_chars[$];
	int         error_count   = 0;
	// Percent chance per cycle that each side holds off.
	int         send_idle_pct = 0;
	int         recv_idle_pct = 0;

	integer_to_ascii_formatter i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always #CLK_HALF clk = ~clk;

	// Map one digit value to its ASCII glyph.
	function automatic logic [7:0] digit_char(input logic [3:0] d);
		if (d < 4'd10) begin
			return CH_ZERO + 8'(d);
		end else begin
			return CH_UPA + 8'(d - 4'd10);
		end
	endfunction

	// Work out the text of one word and queue its characters, sign first,
	// most significant digit next, last one marked.
	task automatic predict_text(input logic [1:0] mode, input logic [31:0] value);
		logic [3:0]  rev_digits [10];
		logic [31:0] mag;
		logic [31:0] radix;
		logic        neg;
		int          ndig;
		char_beat_t  beat;
		ndig  = 0;
		neg   = 1'b0;
		mag   = value;
		radix = 32'd10;
		if (mode == MODE_HEX || mode == MODE_HEX_ALT) begin
			radix = 32'd16;
		end else if (mode == MODE_SDEC && value[31]) begin
			// Negate as an unsigned word, so the most negative value
			// keeps its full magnitude.
			neg = 1'b1;
			mag = ~value + 32'd1;
		end
		// Emit at least one digit, so zero prints as '0'.
		do begin
			rev_digits[ndig] = 4'(mag % radix);
			mag = mag / radix;
			ndig++;
		end while (mag != 0 && ndig < 10);
		if (neg) begin
			beat.code = CH_MINUS;
			beat.last = 1'b0;
			pending_chars.push_back(beat);
		end
		for (int k = ndig - 1; k >= 0; k--) begin
			beat.code = digit_char(rev_digits[k]);
			beat.last = (k == 0);
			pending_chars.push_back(beat);
		end
	endtask

	// Offer one word and hold it until the block takes the request.
	// Leave tvalid high afterwards: the next call either lowers it for a gap
	// or replaces the data in the same step, never both.
	task automatic send_word(input logic [1:0] mode, input logic [31:0] value);
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			do begin
				@(posedge clk);
			end while ($urandom_range(99) < send_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= value;
		s_tuser  <= mode;
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		predict_text(mode, value);
	endtask

	// Ten to the n, n in 0..9.
	function automatic logic [31:0] decade(input int n);
		logic [31:0] p;
		p = 32'd1;
		for (int k = 0; k < n; k++) begin
			p = p * 32'd10;
		end
		return p;
	endfunction

	// Draw a word: full random, short words, words next to a decade
	// boundary, or the negatives of short words.
	function automatic logic [31:0] random_word();
		logic [31:0] w;
		case ($urandom_range(3))
			0: begin
				w = $urandom;
			end
			1: begin
				w = $urandom >> $urandom_range(31);
			end
			2: begin
				w = decade($urandom_range(9)) + 32'($urandom_range(2)) - 32'd1;
			end
			default: begin
				w = ~($urandom >> $urandom_range(31)) + 32'd1;
			end
		endcase
		return w;
	endfunction

	// Zero prints as a single '0' in every mode.
	task automatic test_zero();
		send_word(MODE_UDEC, 32'd0);
		send_word(MODE_SDEC, 32'd0);
		send_word(MODE_HEX, 32'd0);
		send_word(MODE_HEX_ALT, 32'd0);
	endtask

	// All-ones, the largest positive word and one: longest unsigned text,
	// minus one, full hex width.
	task automatic test_extremes();
		send_word(MODE_UDEC, 32'hFFFF_FFFF);
		send_word(MODE_SDEC, 32'hFFFF_FFFF);
		send_word(MODE_HEX, 32'hFFFF_FFFF);
		send_word(MODE_UDEC, 32'h7FFF_FFFF);
		send_word(MODE_SDEC, 32'h7FFF_FFFF);
		send_word(MODE_SDEC, 32'd1);
	endtask

	// The most negative word: no positive twin, eleven characters signed.
	task automatic test_most_negative();
		send_word(MODE_SDEC, 32'h8000_0000);
		send_word(MODE_UDEC, 32'h8000_0000);
		send_word(MODE_HEX, 32'h8000_0000);
		send_word(MODE_SDEC, 32'h8000_0001);
	endtask

	// Digit count steps at each power of ten and of sixteen.
	task automatic test_digit_boundaries();
		send_word(MODE_UDEC, 32'd9);
		send_word(MODE_UDEC, 32'd10);
		send_word(MODE_UDEC, 32'd999_999_999);
		send_word(MODE_UDEC, 32'd1_000_000_000);
		send_word(MODE_HEX, 32'h0FFF_FFFF);
		send_word(MODE_HEX, 32'h1000_0000);
	endtask

	// Mode 3 prints as hex; use every glyph A-F.
	task automatic test_mode_three();
		send_word(MODE_HEX_ALT, 32'hABCD_EF01);
		send_word(MODE_HEX_ALT, 32'h0000_00F0);
		send_word(MODE_HEX, 32'h2345_6789);
	endtask

	// Random words in every mode under the current hold-off setting.
	task automatic test_random_words(input int count);
		for (int n = 0; n < count; n++) begin
			send_word(2'($urandom_range(3)), random_word());
		end
	endtask

	// Check every accepted character against the oldest expectation and
	// drive the receiver's hold-off. One nonblocking write to m_tready per edge.
	always @(posedge clk) begin
		char_beat_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_chars.size() == 0) begin
				$display("%t: unexpected character, expected none, got %h last %b",
					$realtime, m_tdata, m_tlast);
				error_count++;
			end else begin
				want = pending_chars.pop_front();
				if (m_tdata !== want.code) begin
					$display("%t: char_code mismatch, expected %h, got %h",
						$realtime, want.code, m_tdata);
					error_count++;
				end
				if (m_tlast !== want.last) begin
					$display("%t: last mismatch, expected %b, got %b",
						$realtime, want.last, m_tlast);
					error_count++;
				end
			end
		end
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Walk through the tests in turn, then drain and report.
	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Sender rarely idles, receiver often stalls.
		send_idle_pct = 9;
		recv_idle_pct = 68;
		test_zero();
		test_extremes();
		test_most_negative();
		test_digit_boundaries();
		test_mode_three();
		test_random_words(RANDOM_ITEMS);

		// Swap the pressure: slow sender, eager receiver.
		send_idle_pct = 68;
		recv_idle_pct = 9;
		test_random_words(RANDOM_ITEMS);

		// Back to back on both sides.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_words(RANDOM_ITEMS);

		// Drop the last request, wait for its text, then watch for strays.
		s_tvalid <= 1'b0;
		while (pending_chars.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	// Bound the run well above the slowest legal schedule.
	initial begin
		#10ms;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
